>>> hdl/double_ended_queue_with_delete_core_defines.svh
// ----------------------------------------------------------------------------
// Deque core assertion macros
// Shared concurrent assertion shorthands, clocked on clk, reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_WITH_DELETE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_WITH_DELETE_CORE_DEFINES_SVH

// Same-cycle implication
`define DQD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define DQD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/dqd_pkg.sv
// ----------------------------------------------------------------------------
// Deque core package
// Operation and status codes, sequencer states and the control structs.
// ----------------------------------------------------------------------------
package dqd_pkg;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_REMOVE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR
	} state_t;

	// Second operand of the shared wrap adder
	typedef enum logic [1:0] {
		B_ONE,
		B_BACK,
		B_COUNT
	} b_sel_t;

	// Flags from the datapath to the sequencer
	typedef struct packed {
		op_t  op;
		logic is_empty;
		logic is_full;
		logic tag_null;
		logic match;
		logic last;
	} stat_t;

	// Controls from the sequencer to the datapath
	typedef struct packed {
		logic       latch;
		logic       a_ptr;
		b_sel_t     b_sel;
		logic       addr_sum;
		logic       ram_re;
		logic       ram_we;
		logic       wdata_rd;
		logic       head_ld;
		logic       ptr_init;
		logic       ptr_step;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       res_ld;
		logic [1:0] res_status;
		logic       res_item_rd;
	} ctrl_t;

endpackage

>>> hdl/dqd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dqd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/dqd_wrap_add.sv
// ----------------------------------------------------------------------------
// Wrap adder
// Shared pointer unit: adds an offset to a buffer index modulo the depth.
// ----------------------------------------------------------------------------
module dqd_wrap_add #(
	parameter int DEPTH = 16,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic [PW-1:0] a,
	input  logic [CW-1:0] b,
	output logic [PW-1:0] sum
);

	localparam logic [CW:0] DEPTH_W = (CW + 1)'(DEPTH);

	logic [CW:0] raw;
	logic [CW:0] wrapped;

	// Add, then fold back once: both operands stay within the depth
	always_comb begin
		raw     = (CW + 1)'(a) + (CW + 1)'(b);
		wrapped = raw - DEPTH_W;
		sum     = (raw >= DEPTH_W) ? wrapped[PW-1:0] : raw[PW-1:0];
	end

endmodule

>>> hdl/dqd_fsm.sv
// ----------------------------------------------------------------------------
// Deque sequencer
// Steps one operation through buffer reads, compares and moves.
// ----------------------------------------------------------------------------
module dqd_fsm import dqd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output logic  busy,
	output ctrl_t ctrl
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				if (stat.op == OP_REMOVE && !stat.is_empty) begin
					state_d = S_REMOVE;
				end else if (stat.op == OP_DELETE && !stat.is_empty) begin
					state_d = S_SCAN_RD;
				end
			end
			S_REMOVE: begin
				state_d = S_IDLE;
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (stat.match) begin
					state_d = S_SHIFT_RD;
				end else if (stat.last) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SHIFT_RD: begin
				state_d = stat.last ? S_IDLE : S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				state_d = S_SHIFT_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		ctrl       = '0;
		ctrl.b_sel = B_ONE;
		busy       = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				ctrl.latch = start;
			end
			S_EXEC: begin
				case (stat.op)
					OP_APPEND: begin
						ctrl.res_ld = 1'b1;
						if (stat.tag_null) begin
							ctrl.res_status = ST_REFUSED;
						end else if (stat.is_full) begin
							ctrl.res_status = ST_FULL;
						end else begin
							ctrl.b_sel      = B_COUNT;
							ctrl.addr_sum   = 1'b1;
							ctrl.ram_we     = 1'b1;
							ctrl.cnt_inc    = 1'b1;
							ctrl.res_status = ST_DONE;
						end
					end
					OP_INSERT: begin
						ctrl.res_ld = 1'b1;
						if (stat.is_full) begin
							ctrl.res_status = ST_FULL;
						end else begin
							ctrl.b_sel      = B_BACK;
							ctrl.addr_sum   = 1'b1;
							ctrl.ram_we     = 1'b1;
							ctrl.head_ld    = 1'b1;
							ctrl.cnt_inc    = 1'b1;
							ctrl.res_status = ST_DONE;
						end
					end
					OP_REMOVE: begin
						if (stat.is_empty) begin
							ctrl.res_ld     = 1'b1;
							ctrl.res_status = ST_REFUSED;
						end else begin
							ctrl.ram_re = 1'b1;
						end
					end
					OP_DELETE: begin
						if (stat.is_empty) begin
							ctrl.res_ld     = 1'b1;
							ctrl.res_status = ST_REFUSED;
						end else begin
							ctrl.ptr_init = 1'b1;
						end
					end
					default: begin
						ctrl.res_ld     = 1'b1;
						ctrl.res_status = ST_REFUSED;
					end
				endcase
			end
			S_REMOVE: begin
				ctrl.head_ld     = 1'b1;
				ctrl.cnt_dec     = 1'b1;
				ctrl.res_ld      = 1'b1;
				ctrl.res_status  = ST_DONE;
				ctrl.res_item_rd = 1'b1;
			end
			S_SCAN_RD: begin
				ctrl.a_ptr  = 1'b1;
				ctrl.ram_re = 1'b1;
			end
			S_SCAN_CMP: begin
				ctrl.a_ptr = 1'b1;
				if (!stat.match) begin
					if (stat.last) begin
						ctrl.res_ld     = 1'b1;
						ctrl.res_status = ST_REFUSED;
					end else begin
						ctrl.ptr_step = 1'b1;
					end
				end
			end
			S_SHIFT_RD: begin
				ctrl.a_ptr = 1'b1;
				if (stat.last) begin
					ctrl.cnt_dec    = 1'b1;
					ctrl.res_ld     = 1'b1;
					ctrl.res_status = ST_DONE;
				end else begin
					ctrl.addr_sum = 1'b1;
					ctrl.ram_re   = 1'b1;
				end
			end
			S_SHIFT_WR: begin
				ctrl.a_ptr    = 1'b1;
				ctrl.ram_we   = 1'b1;
				ctrl.wdata_rd = 1'b1;
				ctrl.ptr_step = 1'b1;
			end
			default: begin
				ctrl.latch = 1'b0;
			end
		endcase
	end

endmodule

>>> hdl/double_ended_queue_with_delete_core.sv
// ----------------------------------------------------------------------------
// Double-ended queue with delete-by-value
// Bounded deque of 32-bit tags held in a circular buffer RAM.
// ----------------------------------------------------------------------------
// Usage: drive op and item_value with start high; the transaction is taken at
// the clock edge where start is high and busy is low. busy stays high until
// the operation ends. Exactly one result transaction follows each operation:
// done is high for one cycle with status, item_out and length, and the
// receiver must take it then; it cannot stall the block.
// Append back and insert front finish in the execute state; remove front reads
// the front entry there and finishes in the remove state. Delete first match
// walks the buffer with one shared wrap adder and one RAM port: each entry up
// to and including the match is read and then compared, and each later entry
// is read and then written one place toward the front. A new operation may
// start in the cycle that done is shown; no new operation is taken while one
// is still in progress.
// Reset empties the queue at once; the buffer contents are left as they are
// and are never read before being written.
// ----------------------------------------------------------------------------
`include "double_ended_queue_with_delete_core_defines.svh"

module double_ended_queue_with_delete_core import dqd_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [31:0] item_value,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] item_out,
	output logic [4:0]  length
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] BACK_C  = CW'(DEPTH - 1);

	stat_t stat;
	ctrl_t ctrl;

	op_t         op_q;
	logic [31:0] tag_q;
	logic [PW-1:0] head_q;
	logic [PW-1:0] ptr_q;
	logic [PW-1:0] k_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [CW+4:0] count_ext;

	logic [PW-1:0] add_a;
	logic [CW-1:0] add_b;
	logic [PW-1:0] add_sum;
	logic [PW-1:0] ram_addr;
	logic [31:0]   ram_wdata;
	logic [31:0]   ram_rdata;

	logic        done_q;
	logic [1:0]  status_q;
	logic [31:0] item_q;
	logic [4:0]  length_q;

	dqd_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	// Select the operands of the shared wrap adder
	always_comb begin
		add_a = ctrl.a_ptr ? ptr_q : head_q;
		case (ctrl.b_sel)
			B_ONE:   add_b = CW'(1);
			B_BACK:  add_b = BACK_C;
			B_COUNT: add_b = count_q;
			default: add_b = CW'(1);
		endcase
	end

	dqd_wrap_add #(.DEPTH(DEPTH)) u_add (
		.a   (add_a),
		.b   (add_b),
		.sum (add_sum)
	);

	assign ram_addr  = ctrl.addr_sum ? add_sum : add_a;
	assign ram_wdata = ctrl.wdata_rd ? ram_rdata : tag_q;

	dqd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ctrl.ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.re    (ctrl.ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	// Flags for the sequencer
	always_comb begin
		stat.op       = op_q;
		stat.is_empty = (count_q == '0);
		stat.is_full  = (count_q == DEPTH_C);
		stat.tag_null = (tag_q == '0);
		stat.match    = (ram_rdata == tag_q);
		stat.last     = ((CW'(k_q) + CW'(1)) == count_q);
	end

	// Next entry count
	always_comb begin
		count_d = count_q;
		if (ctrl.cnt_inc) begin
			count_d = count_q + CW'(1);
		end else if (ctrl.cnt_dec) begin
			count_d = count_q - CW'(1);
		end
		count_ext = {5'd0, count_d};
	end

	// Hold the accepted operation
	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			op_q  <= op_t'(op);
			tag_q <= item_value;
		end
	end

	// Advance head, walk pointer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			ptr_q   <= '0;
			k_q     <= '0;
			count_q <= '0;
		end else begin
			count_q <= count_d;
			if (ctrl.head_ld) begin
				head_q <= add_sum;
			end
			if (ctrl.ptr_init) begin
				ptr_q <= head_q;
				k_q   <= '0;
			end else if (ctrl.ptr_step) begin
				ptr_q <= add_sum;
				k_q   <= k_q + PW'(1);
			end
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.res_ld;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (ctrl.res_ld) begin
			status_q <= ctrl.res_status;
			item_q   <= ctrl.res_item_rd ? ram_rdata : '0;
			length_q <= count_ext[4:0];
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign item_out = item_q;
	assign length   = length_q;

	`DQD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= DEPTH_C, "entry count above depth")
	`DQD_ASSERT_NOW(a_done_idle, done_q, !busy, "result shown while still busy")
	`DQD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted operation not started")
	`DQD_ASSERT_NOW(a_full_hold, done_q && status_q == ST_FULL, $stable(count_q), "full moved count")
	`DQD_ASSERT_NOW(a_item_done, done_q && item_q != '0, status_q == ST_DONE, "item on refusal")

endmodule

>>> tb/double_ended_queue_with_delete_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Double-ended queue with delete-by-value: self-checking testbench
// Drives append, insert, remove and delete transactions through the start/busy
// handshake with random gaps. A shadow copy of the queue predicts status,
// removed tag and length, and each done strobe is checked against the oldest
// prediction. Directed cases cover the empty and full limits, the null tag and
// deletion at head, middle and tail. Random traffic follows them.
// ----------------------------------------------------------------------------
module double_ended_queue_with_delete_core_test import dqd_pkg::*; ();

	localparam int          DEPTH       = 16;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned SETTLE      = 2 + 2 * DEPTH + 8;
	localparam int unsigned MAX_REPORTS = 100;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] item;
		logic [4:0]  len;
	} deque_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  op;
	logic [31:0] item_value;
	logic        done;
	logic [1:0]  status;
	logic [31:0] item_out;
	logic [4:0]  length;

	// Shadow of the queue contents, front at index 0
	logic [31:0]   shadow_tags[$];
	deque_result_t pending_results[$];

	int unsigned cycle_count;
	int unsigned mismatch_count;
	int unsigned result_count;
	int unsigned op_count[4];
	int unsigned full_count;
	int unsigned refused_count;
	int unsigned peak_length;
	bit          gaps_on;

	double_ended_queue_with_delete_core #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.op        (op),
		.item_value(item_value),
		.done      (done),
		.status    (status),
		.item_out  (item_out),
		.length    (length)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Apply one operation to the shadow queue and return the result it gives
	function automatic void predict_deque_op(input op_t code, input logic [31:0] tag,
			output deque_result_t res);
		int idx;
		idx = -1;
		res.status = ST_DONE;
		res.item   = '0;
		case (code)
			OP_APPEND: begin
				if (tag == '0)
					res.status = ST_REFUSED;
				else if (shadow_tags.size() >= DEPTH)
					res.status = ST_FULL;
				else
					shadow_tags.push_back(tag);
			end
			OP_INSERT: begin
				if (shadow_tags.size() >= DEPTH)
					res.status = ST_FULL;
				else
					shadow_tags.push_front(tag);
			end
			OP_REMOVE: begin
				if (shadow_tags.size() == 0)
					res.status = ST_REFUSED;
				else
					res.item = shadow_tags.pop_front();
			end
			default: begin
				foreach (shadow_tags[i]) begin
					if (idx < 0 && shadow_tags[i] == tag)
						idx = i;
				end
				if (idx < 0)
					res.status = ST_REFUSED;
				else
					shadow_tags.delete(idx);
			end
		endcase
		res.len = 5'(shadow_tags.size());
		op_count[code]++;
		if (res.status == ST_FULL)
			full_count++;
		if (res.status == ST_REFUSED)
			refused_count++;
		if (shadow_tags.size() > peak_length)
			peak_length = shadow_tags.size();
	endfunction

	// Mostly back-to-back, sometimes a short pause, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Send one transaction and record its predicted result once taken
	task automatic issue_op(input op_t code, input logic [31:0] tag);
		int unsigned   gap;
		deque_result_t res;
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		op         <= code;
		item_value <= tag;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predict_deque_op(code, tag, res);
		pending_results.push_back(res);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
					$time, name, want, got);
		end
	endtask

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n === 1'b1 && done !== 1'b0) begin
			result_count++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: result with none pending, expected none actual status %0d",
						$time, status);
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("item_out", want.item, item_out);
				check_field("length", 32'(want.len), 32'(length));
			end
		end
	end

	// Refusals on an empty queue, null append
	task automatic test_empty_queue();
		issue_op(OP_REMOVE, 32'h0000_0000);
		issue_op(OP_DELETE, 32'h0000_0000);
		issue_op(OP_APPEND, 32'h0000_0000);
	endtask

	// Null insert accepted, fill to the limit, then full and null refusals
	task automatic test_fill_to_full();
		logic [31:0] tag;
		issue_op(OP_INSERT, 32'h0000_0000);
		issue_op(OP_INSERT, 32'hFFFF_FFFF);
		for (int k = 0; k < DEPTH - 2; k++) begin
			case (k)
				0:       tag = 32'h8000_0000;
				1:       tag = 32'hAAAA_AAAA;
				2:       tag = 32'h5555_5555;
				default: tag = 32'h0000_0100 + k;
			endcase
			issue_op(OP_APPEND, tag);
		end
		issue_op(OP_APPEND, 32'h0000_0001);
		issue_op(OP_INSERT, 32'h0000_0002);
		// null check takes priority over full
		issue_op(OP_APPEND, 32'h0000_0000);
	endtask

	// Delete a zero tag, the head, the tail, a middle entry and a missing tag
	task automatic test_delete_positions();
		issue_op(OP_DELETE, 32'h0000_0000);
		issue_op(OP_DELETE, 32'hFFFF_FFFF);
		issue_op(OP_DELETE, 32'h0000_010D);
		issue_op(OP_DELETE, 32'h0000_0105);
		issue_op(OP_DELETE, 32'h1234_5678);
		issue_op(OP_REMOVE, 32'h0000_0000);
	endtask

	// Pool of small tags gives duplicates; deletes often target a stored tag
	function automatic logic [31:0] pick_tag(input op_t code);
		int unsigned r;
		if (code == OP_DELETE && shadow_tags.size() != 0 && $urandom_range(0, 2) != 0)
			return shadow_tags[$urandom_range(0, shadow_tags.size() - 1)];
		r = $urandom_range(0, 9);
		if (r == 0)
			return 32'h0000_0000;
		if (r < 4)
			return $urandom_range(1, 6);
		if (r == 4)
			return ~32'($urandom_range(0, 6));
		return $urandom;
	endfunction

	// Epochs that lean towards filling, draining or neither
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned epoch_left;
		int unsigned grow_pct;
		op_t         code;
		epoch_left = 0;
		grow_pct   = 50;
		for (int unsigned i = 0; i < n_items; i++) begin
			if (epoch_left == 0) begin
				case ($urandom_range(0, 2))
					0:       grow_pct = 25;
					1:       grow_pct = 50;
					default: grow_pct = 80;
				endcase
				epoch_left = $urandom_range(20, 120);
				gaps_on    = ($urandom_range(0, 3) != 0);
			end
			epoch_left--;
			if ($urandom_range(0, 99) < grow_pct)
				code = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
			else
				code = $urandom_range(0, 1) ? OP_REMOVE : OP_DELETE;
			issue_op(code, pick_tag(code));
		end
	endtask

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results pending",
			cycle_count, pending_results.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : main
		arst_n         = 1'b0;
		start          = 1'b0;
		op             = OP_APPEND;
		item_value     = '0;
		mismatch_count = 0;
		result_count   = 0;
		full_count     = 0;
		refused_count  = 0;
		peak_length    = 0;
		gaps_on        = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_queue();
		gaps_on = 1'b1;
		test_fill_to_full();
		test_delete_positions();
		test_random_traffic(2000);
		start <= 1'b0;

		// Drain outstanding results, then allow for any stray strobe
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("ran %0d appends, %0d inserts, %0d removes, %0d deletes; %0d results",
			op_count[OP_APPEND], op_count[OP_INSERT], op_count[OP_REMOVE],
			op_count[OP_DELETE], result_count);
		$display("%0d full refusals, %0d other refusals, peak length %0d",
			full_count, refused_count, peak_length);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
